@@ rtl/stack_machine_executor_unit_assert.svh @@
// ----------------------------------------------------------------------------
// Stack machine executor assertion macros
// Shared clocking and reset wrappers for concurrent assertions.
// ----------------------------------------------------------------------------
`ifndef STACK_MACHINE_EXECUTOR_UNIT_ASSERT_SVH
`define STACK_MACHINE_EXECUTOR_UNIT_ASSERT_SVH

// Property checked at every clock edge outside reset.
`define SME_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Condition followed by a consequence in the next cycle.
`define SME_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) pre |=> post) else $error(msg);

`endif

@@ rtl/sme_pkg.sv @@
// ----------------------------------------------------------------------------
// Stack machine executor package
// Opcodes, status codes, controller states and control/status bundles.
// ----------------------------------------------------------------------------
package sme_pkg;

  localparam int OPW  = 6;
  localparam int DW   = 64;
  localparam int PCW  = 16;
  localparam int STW  = 3;
  localparam int OUTW = PCW + 2 * DW;

  typedef enum logic [OPW-1:0] {
    OP_LEA = 6'd0, OP_IMM, OP_JMP, OP_CALL, OP_JZ, OP_JNZ, OP_ENT, OP_ADJ, OP_LEV,
    OP_LI, OP_LC, OP_SI, OP_SC, OP_PUSH, OP_OR, OP_XOR, OP_AND, OP_EQ, OP_NE,
    OP_LT, OP_GT, OP_LE, OP_GE, OP_SHL, OP_SHR, OP_ADD, OP_SUB, OP_MUL, OP_DIV,
    OP_MOD, OP_OPEN, OP_READ, OP_CLOS, OP_PRTF, OP_MALC, OP_MSET, OP_MCMP, OP_EXIT
  } op_e;

  typedef enum logic [STW-1:0] {
    ST_RUN, ST_EXITED, ST_BAD_OP, ST_SYSCALL, ST_DIV_ZERO, ST_BAD_ADDR
  } status_e;

  typedef enum logic [2:0] {
    CS_CLEAR, CS_IDLE, CS_DEC, CS_RD1, CS_RD2, CS_MDW, CS_DONE
  } ctrl_state_e;

  typedef enum logic [2:0] {
    RD_SP, RD_BP, RD_BP1, RD_AX, RD_DATA
  } rd_sel_e;

  typedef struct packed {
    logic    ld_in;
    logic    ld_nptr;
    logic    rd_en;
    rd_sel_e rd_sel;
    logic    cap1;
    logic    cap2;
    logic    md_start;
    logic    commit;
    logic    clr_we;
  } cmd_t;

  typedef struct packed {
    logic [OPW-1:0] op;
    logic           halted;
    logic           md_done;
    logic           out_free;
    logic           clr_last;
  } stat_t;

endpackage

@@ rtl/sme_muldiv.sv @@
// ----------------------------------------------------------------------------
// Multiply / divide unit
// 64-bit multiply over three 32x32 steps; signed divide and remainder by a
// restoring shift-subtract loop, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module sme_muldiv (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic                  is_mul_i,
  input  logic                  is_mod_i,
  input  logic [sme_pkg::DW-1:0] a_i,
  input  logic [sme_pkg::DW-1:0] b_i,
  output logic                  done_o,
  output logic [sme_pkg::DW-1:0] res_o
);
  import sme_pkg::*;

  logic          busy_q, mul_q, done_q;
  logic [6:0]    cnt_q;
  logic          mod_q, na_q, nb_q;
  logic [DW-1:0] acc_q, quo_q, dvs_q, res_q;

  logic [31:0]   mx, my;
  logic [63:0]   prod;
  logic [DW-1:0] mul_sum;
  logic [DW:0]   trial;
  logic          fit;
  logic          mul_last, div_fin;

  always_comb begin
    mx       = cnt_q[0] ? quo_q[63:32] : quo_q[31:0];
    my       = cnt_q[1] ? dvs_q[63:32] : dvs_q[31:0];
    prod     = 64'(mx) * 64'(my);
    mul_sum  = (cnt_q == 7'd0) ? prod : acc_q + {prod[31:0], 32'b0};
    trial    = {acc_q, quo_q[63]} - {1'b0, dvs_q};
    fit      = !trial[DW];
    mul_last = busy_q && mul_q && (cnt_q == 7'd2);
    div_fin  = busy_q && !mul_q && cnt_q[6];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      mul_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= mul_last || div_fin;
      if (start_i) begin
        busy_q <= 1'b1;
        mul_q  <= is_mul_i;
        cnt_q  <= '0;
      end else if (mul_last || div_fin) begin
        busy_q <= 1'b0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 7'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q <= '0;
      mod_q <= is_mod_i;
      na_q  <= a_i[DW-1];
      nb_q  <= b_i[DW-1];
      if (is_mul_i) begin
        quo_q <= a_i;
        dvs_q <= b_i;
      end else begin
        quo_q <= a_i[DW-1] ? -a_i : a_i;
        dvs_q <= b_i[DW-1] ? -b_i : b_i;
      end
    end else if (busy_q && mul_q) begin
      acc_q <= mul_sum;
      if (mul_last) res_q <= mul_sum;
    end else if (div_fin) begin
      if (mod_q) res_q <= na_q ? -acc_q : acc_q;
      else       res_q <= (na_q ^ nb_q) ? -quo_q : quo_q;
    end else if (busy_q) begin
      acc_q <= fit ? trial[DW-1:0] : {acc_q[DW-2:0], quo_q[DW-1]};
      quo_q <= {quo_q[DW-2:0], fit};
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

@@ rtl/sme_datapath.sv @@
// ----------------------------------------------------------------------------
// Stack machine executor datapath
// Architectural registers, data memory, operand capture, instruction commit
// and the result register.
// ----------------------------------------------------------------------------
module sme_datapath #(
  parameter int MEM_WORDS = 4096
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  sme_pkg::cmd_t           cmd_i,
  output sme_pkg::stat_t          stat_o,
  input  logic                    cfg_we_i,
  input  logic [sme_pkg::PCW-1:0] cfg_wdata_i,
  input  logic [sme_pkg::DW-1:0]  in_operand_i,
  input  logic [sme_pkg::OPW-1:0] in_op_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [sme_pkg::OUTW-1:0] out_data_o,
  output logic [sme_pkg::STW-1:0] out_status_o
);
  import sme_pkg::*;

  localparam int MB  = MEM_WORDS * 8;
  localparam int AW  = $clog2(MB + 1);
  localparam int WIW = $clog2(MEM_WORDS);
  localparam logic [DW-1:0] MB64 = DW'(MB);
  localparam logic [AW-1:0] MBA  = AW'(MB);

  logic [DW-1:0]  mem [MEM_WORDS];
  logic [DW-1:0]  rdata_q;

  logic [PCW-1:0] pc_q;
  logic [DW-1:0]  ax_q, hexit_q;
  logic [AW-1:0]  sp_q, bp_q;
  logic           halted_q, started_q, out_valid_q;
  status_e        hstat_q;
  logic [WIW-1:0] clr_cnt_q;

  logic [OPW-1:0] op_q;
  logic [DW-1:0]  opd_q, nptr_q, tmp_q, tmp2_q;
  logic [OUTW-1:0] out_data_q;
  logic [STW-1:0] out_user_q;

  logic           md_done;
  logic [DW-1:0]  md_res;

  logic [WIW-1:0] raddr, widx, c_widx;
  logic [DW-1:0]  wdata, c_wdata;
  logic           mem_we, c_we;

  logic [PCW-1:0] pc1, pc2, tgt, n_pc;
  logic [AW-1:0]  spm8, spp8, n_sp, n_bp;
  logic [AW:0]    bp16;
  logic           sp_lt8, sp_empty;
  logic [DW-1:0]  opd8, n_ax, n_hexit, alu, sc_word;
  logic [7:0]     lc_byte;
  status_e        n_stat, st_out;
  logic           out_free;

  function automatic logic ptr_ok(input logic [DW-1:0] v);
    return (v <= MB64) && (v[2:0] == 3'b000);
  endfunction

  function automatic logic word_ok(input logic [DW-1:0] v);
    return (v < MB64) && (v[2:0] == 3'b000);
  endfunction

  function automatic logic [DW-1:0] sext8(input logic [7:0] b);
    return {{(DW-8){b[7]}}, b};
  endfunction

  sme_muldiv u_muldiv (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (cmd_i.md_start),
    .is_mul_i (op_q == OP_MUL),
    .is_mod_i (op_q == OP_MOD),
    .a_i      (rdata_q),
    .b_i      (ax_q),
    .done_o   (md_done),
    .res_o    (md_res)
  );

  always_comb begin
    case (cmd_i.rd_sel)
      RD_SP:   raddr = sp_q[3 +: WIW];
      RD_BP:   raddr = bp_q[3 +: WIW];
      RD_BP1:  raddr = bp_q[3 +: WIW] + WIW'(1);
      RD_AX:   raddr = ax_q[3 +: WIW];
      RD_DATA: raddr = rdata_q[3 +: WIW];
      default: raddr = sp_q[3 +: WIW];
    endcase
  end

  always_comb begin
    pc1      = pc_q + PCW'(1);
    pc2      = pc_q + PCW'(2);
    tgt      = opd_q[PCW-1:0];
    spm8     = sp_q - AW'(8);
    spp8     = sp_q + AW'(8);
    bp16     = {1'b0, bp_q} + (AW+1)'(16);
    sp_lt8   = sp_q < AW'(8);
    sp_empty = sp_q >= MBA;
    opd8     = {opd_q[DW-4:0], 3'b000};
    lc_byte  = tmp_q[{ax_q[2:0], 3'b000} +: 8];
    for (int b = 0; b < 8; b++) begin
      sc_word[b*8 +: 8] = (tmp_q[2:0] == 3'(b)) ? ax_q[7:0] : tmp2_q[b*8 +: 8];
    end

    case (op_e'(op_q))
      OP_OR:   alu = tmp_q | ax_q;
      OP_XOR:  alu = tmp_q ^ ax_q;
      OP_AND:  alu = tmp_q & ax_q;
      OP_EQ:   alu = DW'(tmp_q == ax_q);
      OP_NE:   alu = DW'(tmp_q != ax_q);
      OP_LT:   alu = DW'($signed(tmp_q) < $signed(ax_q));
      OP_GT:   alu = DW'($signed(ax_q) < $signed(tmp_q));
      OP_LE:   alu = DW'(!($signed(ax_q) < $signed(tmp_q)));
      OP_GE:   alu = DW'(!($signed(tmp_q) < $signed(ax_q)));
      OP_SHL:  alu = tmp_q << ax_q[5:0];
      OP_SHR:  alu = DW'($signed(tmp_q) >>> ax_q[5:0]);
      OP_ADD:  alu = tmp_q + ax_q;
      OP_SUB:  alu = tmp_q - ax_q;
      default: alu = md_res;
    endcase

    n_pc    = pc_q;
    n_ax    = ax_q;
    n_sp    = sp_q;
    n_bp    = bp_q;
    n_hexit = hexit_q;
    n_stat  = ST_RUN;
    c_we    = 1'b0;
    c_widx  = spm8[3 +: WIW];
    c_wdata = ax_q;

    if (!halted_q) begin
      case (op_e'(op_q))
        OP_LEA: begin
          n_ax = nptr_q;
          n_pc = pc2;
        end
        OP_IMM: begin
          n_ax = opd_q;
          n_pc = pc2;
        end
        OP_JMP: n_pc = tgt;
        OP_CALL: begin
          if (sp_lt8) n_stat = ST_BAD_ADDR;
          else begin
            c_we    = 1'b1;
            c_wdata = DW'(pc2);
            n_sp    = spm8;
            n_pc    = tgt;
          end
        end
        OP_JZ:  n_pc = (ax_q != '0) ? pc2 : tgt;
        OP_JNZ: n_pc = (ax_q != '0) ? tgt : pc2;
        OP_ENT: begin
          if (sp_lt8 || !ptr_ok(nptr_q)) n_stat = ST_BAD_ADDR;
          else begin
            c_we    = 1'b1;
            c_wdata = DW'(bp_q);
            n_bp    = spm8;
            n_sp    = nptr_q[AW-1:0];
            n_pc    = pc2;
          end
        end
        OP_ADJ: begin
          if (!ptr_ok(nptr_q)) n_stat = ST_BAD_ADDR;
          else begin
            n_sp = nptr_q[AW-1:0];
            n_pc = pc2;
          end
        end
        OP_LEV: begin
          if (bp16 > (AW+1)'(MB) || !ptr_ok(tmp_q)) n_stat = ST_BAD_ADDR;
          else begin
            n_bp = tmp_q[AW-1:0];
            n_sp = bp16[AW-1:0];
            n_pc = tmp2_q[PCW-1:0];
          end
        end
        OP_LI: begin
          if (!word_ok(ax_q)) n_stat = ST_BAD_ADDR;
          else begin
            n_ax = tmp_q;
            n_pc = pc1;
          end
        end
        OP_LC: begin
          if (ax_q >= MB64) n_stat = ST_BAD_ADDR;
          else begin
            n_ax = sext8(lc_byte);
            n_pc = pc1;
          end
        end
        OP_SI: begin
          if (sp_empty || !word_ok(tmp_q)) n_stat = ST_BAD_ADDR;
          else begin
            c_we    = 1'b1;
            c_widx  = tmp_q[3 +: WIW];
            n_sp    = spp8;
            n_pc    = pc1;
          end
        end
        OP_SC: begin
          if (sp_empty || tmp_q >= MB64) n_stat = ST_BAD_ADDR;
          else begin
            c_we    = 1'b1;
            c_widx  = tmp_q[3 +: WIW];
            c_wdata = sc_word;
            n_ax    = sext8(ax_q[7:0]);
            n_sp    = spp8;
            n_pc    = pc1;
          end
        end
        OP_PUSH: begin
          if (sp_lt8) n_stat = ST_BAD_ADDR;
          else begin
            c_we = 1'b1;
            n_sp = spm8;
            n_pc = pc1;
          end
        end
        OP_OR, OP_XOR, OP_AND, OP_EQ, OP_NE, OP_LT, OP_GT, OP_LE, OP_GE,
        OP_SHL, OP_SHR, OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD: begin
          if (sp_empty) n_stat = ST_BAD_ADDR;
          else if ((op_q == OP_DIV || op_q == OP_MOD) && ax_q == '0) n_stat = ST_DIV_ZERO;
          else begin
            n_ax = alu;
            n_sp = spp8;
            n_pc = pc1;
          end
        end
        OP_OPEN, OP_READ, OP_CLOS, OP_PRTF, OP_MALC, OP_MSET, OP_MCMP:
          n_stat = ST_SYSCALL;
        OP_EXIT: begin
          if (sp_empty) n_stat = ST_BAD_ADDR;
          else begin
            n_stat  = ST_EXITED;
            n_hexit = tmp_q;
            n_pc    = pc1;
          end
        end
        default: n_stat = ST_BAD_OP;
      endcase
    end

    st_out   = halted_q ? hstat_q : n_stat;
    out_free = !out_valid_q || out_ready_i;
    mem_we   = cmd_i.clr_we || (cmd_i.commit && c_we);
    widx     = cmd_i.clr_we ? clr_cnt_q : c_widx;
    wdata    = cmd_i.clr_we ? '0 : c_wdata;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[widx] <= wdata;
    if (cmd_i.rd_en) rdata_q <= mem[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q        <= '0;
      ax_q        <= '0;
      sp_q        <= MBA;
      bp_q        <= MBA;
      hexit_q     <= '0;
      halted_q    <= 1'b0;
      hstat_q     <= ST_RUN;
      started_q   <= 1'b0;
      out_valid_q <= 1'b0;
      clr_cnt_q   <= '0;
    end else begin
      if (cmd_i.clr_we) clr_cnt_q <= clr_cnt_q + WIW'(1);
      if (cmd_i.ld_in) started_q <= 1'b1;
      if (cfg_we_i && !started_q) pc_q <= cfg_wdata_i;
      if (cmd_i.commit) begin
        pc_q        <= n_pc;
        ax_q        <= n_ax;
        sp_q        <= n_sp;
        bp_q        <= n_bp;
        hexit_q     <= n_hexit;
        out_valid_q <= 1'b1;
        if (!halted_q && n_stat != ST_RUN) begin
          halted_q <= 1'b1;
          hstat_q  <= n_stat;
        end
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_in) begin
      op_q  <= in_op_i;
      opd_q <= in_operand_i;
    end
    if (cmd_i.ld_nptr) begin
      case (op_e'(op_q))
        OP_ENT:  nptr_q <= {{(DW-AW){1'b0}}, spm8} - opd8;
        OP_ADJ:  nptr_q <= DW'(sp_q) + opd8;
        default: nptr_q <= DW'(bp_q) + opd8;
      endcase
    end
    if (cmd_i.cap1) tmp_q <= rdata_q;
    if (cmd_i.cap2) tmp2_q <= rdata_q;
    if (cmd_i.commit) begin
      out_data_q <= {(st_out == ST_EXITED) ? n_hexit : '0, n_ax, n_pc};
      out_user_q <= st_out;
    end
  end

  always_comb begin
    stat_o.op       = op_q;
    stat_o.halted   = halted_q;
    stat_o.md_done  = md_done;
    stat_o.out_free = out_free;
    stat_o.clr_last = clr_cnt_q == WIW'(MEM_WORDS - 1);
  end

  assign out_valid_o  = out_valid_q;
  assign out_data_o   = out_data_q;
  assign out_status_o = out_user_q;

endmodule

@@ rtl/sme_ctrl.sv @@
// ----------------------------------------------------------------------------
// Stack machine executor controller
// Sequences memory clear, instruction accept, operand reads, multiply/divide
// and commit.
// ----------------------------------------------------------------------------
module sme_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  sme_pkg::stat_t stat_i,
  output sme_pkg::cmd_t  cmd_o
);
  import sme_pkg::*;

  ctrl_state_e state_q, state_d;
  op_e         op;
  logic        alu_op, need_rd1, need_rd2, md_op;
  rd_sel_e     rd1_sel;

  always_comb begin
    op       = op_e'(stat_i.op);
    alu_op   = (stat_i.op >= OP_OR) && (stat_i.op <= OP_MOD);
    need_rd1 = !stat_i.halted && (alu_op || op == OP_LEV || op == OP_LI ||
               op == OP_LC || op == OP_SI || op == OP_SC || op == OP_EXIT);
    need_rd2 = op == OP_LEV || op == OP_SC;
    md_op    = op == OP_MUL || op == OP_DIV || op == OP_MOD;
    case (op)
      OP_LEV:       rd1_sel = RD_BP;
      OP_LI, OP_LC: rd1_sel = RD_AX;
      default:      rd1_sel = RD_SP;
    endcase
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      CS_CLEAR: if (stat_i.clr_last) state_d = CS_IDLE;
      CS_IDLE:  if (in_valid_i) state_d = CS_DEC;
      CS_DEC:   state_d = need_rd1 ? CS_RD1 : CS_DONE;
      CS_RD1: begin
        if (need_rd2)   state_d = CS_RD2;
        else if (md_op) state_d = CS_MDW;
        else            state_d = CS_DONE;
      end
      CS_RD2:   state_d = CS_DONE;
      CS_MDW:   if (stat_i.md_done) state_d = CS_DONE;
      CS_DONE:  if (stat_i.out_free) state_d = CS_IDLE;
      default:  state_d = CS_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    cmd_o.rd_sel = RD_SP;
    in_ready_o = 1'b0;
    case (state_q)
      CS_CLEAR: cmd_o.clr_we = 1'b1;
      CS_IDLE: begin
        in_ready_o  = 1'b1;
        cmd_o.ld_in = in_valid_i;
      end
      CS_DEC: begin
        cmd_o.ld_nptr = 1'b1;
        cmd_o.rd_en   = need_rd1;
        cmd_o.rd_sel  = rd1_sel;
      end
      CS_RD1: begin
        cmd_o.cap1     = 1'b1;
        cmd_o.rd_en    = need_rd2;
        cmd_o.rd_sel   = (op == OP_LEV) ? RD_BP1 : RD_DATA;
        cmd_o.md_start = md_op;
      end
      CS_RD2:  cmd_o.cap2 = 1'b1;
      CS_DONE: cmd_o.commit = stat_i.out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= CS_CLEAR;
    else         state_q <= state_d;
  end

endmodule

@@ rtl/stack_machine_executor_unit.sv @@
// ----------------------------------------------------------------------------
// Stack machine executor
// Executes one accumulator/stack virtual machine instruction per transfer.
//
//  channel   dir  handshake                     payload
//  cfg       in   cfg_we_i                      cfg_wdata_i: start_address
//  s_axis    in   s_axis_tvalid_i/tready_o      tdata: operand; tuser: op
//  m_axis    out  m_axis_tvalid_o/tready_i      tdata: next_pc, acc, exit; tuser: status
//
// After reset the data memory is cleared one word at a time; no input is
// taken meanwhile. An instruction passes accept, decode and commit, plus a
// read state per stack or memory read (two for LEV and SC through the single
// memory read port); MUL runs three 32x32 steps and DIV/MOD one quotient
// bit per cycle. A stalled result waits in the output register; the next
// instruction is taken meanwhile and commits once that register is free.
// ----------------------------------------------------------------------------
module stack_machine_executor_unit #(
  parameter int MEM_WORDS = 4096
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [sme_pkg::PCW-1:0]  cfg_wdata_i,
  input  logic                     s_axis_tvalid_i,
  output logic                     s_axis_tready_o,
  input  logic [sme_pkg::DW-1:0]   s_axis_tdata_i,   // [63:0] operand
  input  logic [sme_pkg::OPW-1:0]  s_axis_tuser_i,   // [5:0] op
  output logic                     m_axis_tvalid_o,
  input  logic                     m_axis_tready_i,
  output logic [sme_pkg::OUTW-1:0] m_axis_tdata_o,   // [15:0] next_pc, [79:16] acc_value,
                                                     // [143:80] exit_value
  output logic [sme_pkg::STW-1:0]  m_axis_tuser_o    // [2:0] status
);
  import sme_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  sme_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  sme_datapath #(
    .MEM_WORDS (MEM_WORDS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_operand_i (s_axis_tdata_i),
    .in_op_i      (s_axis_tuser_i),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .out_data_o   (m_axis_tdata_o),
    .out_status_o (m_axis_tuser_o)
  );

endmodule

@@ rtl/sme_chk.sv @@
// ----------------------------------------------------------------------------
// Stack machine executor checker
// Port-level checks on result stability under stall, halt behavior, the exit field and transfer counts.
// ----------------------------------------------------------------------------
`include "stack_machine_executor_unit_assert.svh"

module sme_chk (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     s_axis_tvalid_i,
  input logic                     s_axis_tready_o,
  input logic                     m_axis_tvalid_o,
  input logic                     m_axis_tready_i,
  input logic [sme_pkg::OUTW-1:0] m_axis_tdata_o,
  input logic [sme_pkg::STW-1:0]  m_axis_tuser_o
);
  import sme_pkg::*;

  logic [1:0]      pend_q;
  logic            halt_seen_q;
  logic [OUTW-1:0] last_data_q;
  logic [STW-1:0]  last_user_q;
  logic            s_xfer, m_xfer;

  assign s_xfer = s_axis_tvalid_i && s_axis_tready_o;
  assign m_xfer = m_axis_tvalid_o && m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q      <= '0;
      halt_seen_q <= 1'b0;
    end else begin
      pend_q <= pend_q + 2'(s_xfer) - 2'(m_xfer);
      if (m_xfer && m_axis_tuser_o != ST_RUN) halt_seen_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (m_xfer) begin
      last_data_q <= m_axis_tdata_o;
      last_user_q <= m_axis_tuser_o;
    end
  end

  `SME_ASSERT_NEXT(a_out_hold, m_axis_tvalid_o && !m_axis_tready_i, m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o), "result changed while stalled")
  `SME_ASSERT(a_halt_repeat, m_axis_tvalid_o && halt_seen_q |-> m_axis_tdata_o == last_data_q && m_axis_tuser_o == last_user_q, "halted result not repeated")
  `SME_ASSERT(a_exit_zero, m_axis_tvalid_o && m_axis_tuser_o != ST_EXITED |-> m_axis_tdata_o[OUTW-1:PCW+DW] == '0, "exit value set without exit")
  `SME_ASSERT(a_no_extra, m_axis_tvalid_o |-> pend_q != 2'd0 && !(s_xfer && pend_q > 2'd1), "result without instruction")

endmodule

bind stack_machine_executor_unit sme_chk u_sme_chk (.*);
